// File: design/hmg_pkg.sv
`default_nettype none

package hmg_pkg;

   localparam int SIDE_W   = 10;
   localparam int MAX_SIDE = 1023;
   localparam int HGT_W    = 13;
   localparam int POS_W    = 28;
   localparam int BLK_W    = 16;
   localparam int STEP_W   = 24;
   localparam int TEX_W    = 34;
   localparam int IDX_W    = 20;
   localparam int LUMA_W   = 18;
   // 32 * luma + 625, so that height = num / 1250 rounds half up
   localparam int NUM_W    = 23;
   localparam int RECIP_W  = 24;
   localparam int RECIP_SHIFT = 34;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd13743896;
   localparam logic [NUM_W-1:0]   ROUND_OFS = 23'd625;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 24;
   localparam logic [CSR_AW-1:0] CSR_GRID_COLUMNS = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_GRID_ROWS    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_BLOCK_SIZE   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_U_STEP       = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_V_STEP       = 3'd4;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
   } req_data_type;

   typedef struct packed {
      logic                    item_kind;
      logic signed [POS_W-1:0] pos_x;
      logic [HGT_W-1:0]        pos_height;
      logic signed [POS_W-1:0] pos_z;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
      logic [HGT_W-1:0]        peak_height;
      logic                    run_end;
   } rsp_data_type;

   typedef struct packed {
      logic [SIDE_W-1:0] grid_columns;
      logic [SIDE_W-1:0] grid_rows;
      logic [BLK_W-1:0]  block_size;
      logic [STEP_W-1:0] u_step;
      logic [STEP_W-1:0] v_step;
   } cfg_type;

   typedef struct packed {
      logic [SIDE_W-1:0] column;
      logic [SIDE_W-1:0] row;
      logic [NUM_W-1:0]  num;
      logic              tri_cell;
      logic              first;
   } q_entry_type;

   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0] res;
      if (side == '0) begin
         res = SIDE_W'(1);
      end else if (int'(side) > MAX_SIDE) begin
         res = SIDE_W'(MAX_SIDE);
      end else begin
         res = side;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/hmg_queue.sv
`default_nettype none

module hmg_queue
   import hmg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_push,
   input  wire q_entry_type q_wdata,
   output logic             q_full,
   input  wire logic        q_pop,
   output logic             q_empty,
   output q_entry_type      q_head
);

   q_entry_type       mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full  = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = mem_ff[rd_ptr_ff];

   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (Q_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

`default_nettype wire

// File: design/hmg_front.sv
`default_nettype none

module hmg_front
   import hmg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         req_push,
   input  wire req_data_type req_data,
   output logic              req_full,
   input  wire logic         q_full,
   output logic              q_push,
   output q_entry_type       q_wdata
);

   logic [SIDE_W-1:0] col_ff, col_in;
   logic [SIDE_W-1:0] row_ff, row_in;
   logic [SIDE_W-1:0] cols, rows;
   logic              last_col, last_row, accept;
   logic [LUMA_W-1:0] luma;

   assign cols = eff_side(cfg.grid_columns);
   assign rows = eff_side(cfg.grid_rows);

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept;

   // a counter left beyond a lowered size counts as being on the last column or row
   assign last_col = ((SIDE_W+1)'(col_ff) + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(cols);
   assign last_row = ((SIDE_W+1)'(row_ff) + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(rows);

   // bt.601 luma with weights scaled by 1000
   assign luma = LUMA_W'(req_data.pixel_red)   * LUMA_W'(299)
               + LUMA_W'(req_data.pixel_green) * LUMA_W'(587)
               + LUMA_W'(req_data.pixel_blue)  * LUMA_W'(114);

   always_comb begin
      q_wdata.column   = col_ff;
      q_wdata.row      = row_ff;
      q_wdata.num      = {luma, 5'b0} + ROUND_OFS;
      q_wdata.tri_cell = !last_col && !last_row;
      q_wdata.first    = (col_ff == '0) && (row_ff == '0);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + SIDE_W'(1);
         end else begin
            col_in = col_ff + SIDE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

// File: design/hmg_back.sv
`default_nettype none

module hmg_back
   import hmg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_empty,
   input  wire q_entry_type q_head,
   output logic             q_pop,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_data_type     rsp_data
);

   localparam logic [1:0] BEAT_VERTEX = 2'd0;
   localparam logic [1:0] BEAT_TRI_A  = 2'd1;
   localparam logic [1:0] BEAT_TRI_B  = 2'd2;

   localparam int PROD_W = NUM_W + RECIP_W;

   logic [SIDE_W-1:0]       cols, rows;
   logic [SIDE_W-1:0]       half_c, half_r;
   logic signed [SIDE_W:0]  dx, dz;
   logic signed [POS_W-1:0] px, pz, blk;
   logic [TEX_W-1:0]        tu, tv;
   logic [IDX_W-1:0]        idx;
   logic [PROD_W-1:0]       prod;

   logic                    w_vld_ff, w_vld_in;
   logic [1:0]              w_beat_ff, w_beat_in;
   logic                    w_tri_ff, w_first_ff;
   logic signed [POS_W-1:0] w_px_ff, w_pz_ff;
   logic [TEX_W-1:0]        w_u_ff, w_v_ff;
   logic [HGT_W-1:0]        w_h_ff;
   logic [IDX_W-1:0]        w_idx_ff;

   logic [HGT_W-1:0]        peak_ff, peak_in, peak_new;
   logic                    out_vld_ff, out_vld_in;
   rsp_data_type            out_data_ff;
   rsp_data_type            emit;
   logic [IDX_W-1:0]        idx_j;
   logic                    last_beat, out_ld, w_free;

   assign cols   = eff_side(cfg.grid_columns);
   assign rows   = eff_side(cfg.grid_rows);
   assign half_c = (cols - SIDE_W'(1)) >> 1;
   assign half_r = (rows - SIDE_W'(1)) >> 1;

   // products for the item at the head of the queue, registered into the work stage
   assign dx   = $signed({1'b0, q_head.column}) - $signed({1'b0, half_c});
   assign dz   = $signed({1'b0, q_head.row}) - $signed({1'b0, half_r});
   assign blk  = $signed(POS_W'({1'b0, cfg.block_size}));
   assign px   = POS_W'(dx) * blk;
   assign pz   = POS_W'(dz) * blk;
   assign tu   = TEX_W'(q_head.column) * TEX_W'(cfg.u_step);
   assign tv   = TEX_W'(q_head.row) * TEX_W'(cfg.v_step);
   assign idx  = IDX_W'(q_head.row) * IDX_W'(cols) + IDX_W'(q_head.column);
   // divide by 1250 through the reciprocal, exact over the whole input range
   assign prod = PROD_W'(q_head.num) * PROD_W'(RECIP_MUL);

   assign last_beat = !w_tri_ff || (w_beat_ff == BEAT_TRI_B);
   assign out_ld    = w_vld_ff && (!out_vld_ff || rsp_pop);
   assign w_free    = !w_vld_ff || (out_ld && last_beat);
   assign q_pop     = !q_empty && w_free;

   assign peak_new = (w_first_ff || (w_h_ff > peak_ff)) ? w_h_ff : peak_ff;
   assign idx_j    = w_idx_ff + IDX_W'(cols);

   always_comb begin
      emit = '0;
      emit.peak_height = peak_ff;
      unique case (w_beat_ff)
         BEAT_VERTEX: begin
            emit.item_kind   = KIND_VERTEX;
            emit.pos_x       = w_px_ff;
            emit.pos_height  = w_h_ff;
            emit.pos_z       = w_pz_ff;
            emit.tex_u       = w_u_ff;
            emit.tex_v       = w_v_ff;
            emit.peak_height = peak_new;
            emit.run_end     = !w_tri_ff;
         end
         BEAT_TRI_A: begin
            emit.item_kind = KIND_TRIANGLE;
            emit.corner_a  = w_idx_ff;
            emit.corner_b  = idx_j;
            emit.corner_c  = w_idx_ff + IDX_W'(1);
            emit.run_end   = 1'b0;
         end
         BEAT_TRI_B: begin
            emit.item_kind = KIND_TRIANGLE;
            emit.corner_a  = w_idx_ff + IDX_W'(1);
            emit.corner_b  = idx_j;
            emit.corner_c  = idx_j + IDX_W'(1);
            emit.run_end   = 1'b1;
         end
         default: begin
            emit = '0;
         end
      endcase
   end

   always_comb begin
      w_vld_in  = w_vld_ff;
      w_beat_in = w_beat_ff;
      if (q_pop) begin
         w_vld_in  = 1'b1;
         w_beat_in = BEAT_VERTEX;
      end else if (out_ld) begin
         if (last_beat) begin
            w_vld_in = 1'b0;
         end else begin
            w_beat_in = w_beat_ff + 2'd1;
         end
      end
      peak_in    = (out_ld && (w_beat_ff == BEAT_VERTEX)) ? peak_new : peak_ff;
      out_vld_in = out_ld ? 1'b1 : (rsp_pop ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff   <= 1'b0;
         w_beat_ff  <= BEAT_VERTEX;
         peak_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         w_vld_ff   <= w_vld_in;
         w_beat_ff  <= w_beat_in;
         peak_ff    <= peak_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         w_tri_ff   <= q_head.tri_cell;
         w_first_ff <= q_head.first;
         w_px_ff    <= px;
         w_pz_ff    <= pz;
         w_u_ff     <= tu;
         w_v_ff     <= tv;
         w_h_ff     <= prod[RECIP_SHIFT +: HGT_W];
         w_idx_ff   <= idx;
      end
      if (out_ld) begin
         out_data_ff <= emit;
      end
   end

   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// File: design/heightmap_grid_mesh_generator_top.sv
// Heightmap mesh generator: pixels go in on a push/full port in raster order and each
// gives a vertex result, followed by two triangle results unless the pixel lies on the
// last row or last column. The front end accepts one pixel per cycle, while the queue is not
// full, into a four-entry queue; the back end emits one result per cycle, while the receiver
// keeps popping, into a single output register, so a pixel with triangles occupies the back
// end for three results and an edge pixel for one. Throughput is set by the result port.
// On an otherwise idle block the vertex of an accepted pixel goes through the queue, the work
// register and the output register to the result port. Registers are written through the csr
// port at any time, but only take effect as intended while no pixel is in flight.
`default_nettype none

module heightmap_grid_mesh_generator_top
   import hmg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire req_data_type       req_data,
   output logic                    req_full,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output rsp_data_type            rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CSR_AW-1:0]  csr_index,
   input  wire logic [CSR_DW-1:0]  csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_full, q_empty, q_push, q_pop;
   q_entry_type  q_wdata, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: cfg_in.grid_columns = csr_wdata[SIDE_W-1:0];
            CSR_GRID_ROWS:    cfg_in.grid_rows    = csr_wdata[SIDE_W-1:0];
            CSR_BLOCK_SIZE:   cfg_in.block_size   = csr_wdata[BLK_W-1:0];
            CSR_U_STEP:       cfg_in.u_step       = csr_wdata[STEP_W-1:0];
            CSR_V_STEP:       cfg_in.v_step       = csr_wdata[STEP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_columns <= SIDE_W'(3);
         cfg_ff.grid_rows    <= SIDE_W'(3);
         cfg_ff.block_size   <= BLK_W'(1280);
         cfg_ff.u_step       <= STEP_W'(32768);
         cfg_ff.v_step       <= STEP_W'(32768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hmg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   hmg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   hmg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: design/hmg_checker.sv
`default_nettype none

module hmg_checker
   import hmg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rsp_empty,
   input  wire logic         rsp_pop,
   input  wire rsp_data_type rsp_data
);

   logic       rsp_xfer;
   logic [1:0] tri_left_ff, tri_left_in;

   assign rsp_xfer = rsp_pop && !rsp_empty;

   // triangles still owed by the last vertex transfer
   always_comb begin
      tri_left_in = tri_left_ff;
      if (rsp_xfer) begin
         if (rsp_data.item_kind == KIND_VERTEX) begin
            tri_left_in = rsp_data.run_end ? 2'd0 : 2'd2;
         end else if (tri_left_ff != 2'd0) begin
            tri_left_in = tri_left_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tri_left_ff <= 2'd0;
      end else begin
         tri_left_ff <= tri_left_in;
      end
   end

   a_vertex_after_tris: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_data.item_kind == KIND_VERTEX) |-> tri_left_ff == 2'd0)
      else $error("vertex transferred while triangles still owed");

   a_tri_follows_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_data.item_kind == KIND_TRIANGLE)
         |-> (tri_left_ff != 2'd0) && (rsp_data.run_end == (tri_left_ff == 2'd1)))
      else $error("triangle out of order or wrong run end");

   a_peak_covers_height: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_data.item_kind == KIND_VERTEX)
         |-> rsp_data.peak_height >= rsp_data.pos_height)
      else $error("peak below vertex height");

   a_first_tri_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_data.item_kind == KIND_TRIANGLE) && !rsp_data.run_end
         |-> rsp_data.corner_c == rsp_data.corner_a + IDX_W'(1))
      else $error("first triangle corners inconsistent");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind heightmap_grid_mesh_generator_top hmg_checker u_hmg_checker (.*);

`default_nettype wire

// File: verif/heightmap_grid_mesh_generator_top_tb.sv
`timescale 1ns / 100ps

module heightmap_grid_mesh_generator_top_tb;
   import hmg_pkg::*;

   localparam int unsigned LUMA_R      = 299;
   localparam int unsigned LUMA_G      = 587;
   localparam int unsigned LUMA_B      = 114;
   localparam int unsigned HGT_ROUND   = 5000;
   localparam int unsigned HGT_DIV     = 10000;
   localparam int          MAX_WAIT    = 17;
   localparam int          STALL_LIMIT = 3000;
   localparam int          PIXEL_GOAL  = 390;
   localparam int          PRINT_LIMIT = 50;
   // index with no register behind it, writes must be ignored
   localparam logic [CSR_AW-1:0] CSR_SPARE = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   req_data_type       req_data = '0;
   logic               req_full;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   rsp_data_type       rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_AW-1:0]  csr_index = '0;
   logic [CSR_DW-1:0]  csr_wdata = '0;

   // mesh state as the block should hold it
   cfg_type mesh_cfg = '{grid_columns: 10'd3, grid_rows: 10'd3, block_size: 16'd1280,
                         u_step: 24'd32768, v_step: 24'd32768};
   int unsigned        col_ctr = 0;
   int unsigned        row_ctr = 0;
   logic [HGT_W-1:0]   peak_hgt = '0;

   rsp_data_type       expected_items[$];
   int                 error_count = 0;
   int                 results_seen = 0;
   int                 pixels_sent = 0;
   int                 rsp_hold = 0;
   bit                 pacing = 1'b1;
   int                 quiet_cycles = 0;

   heightmap_grid_mesh_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR: %s", msg);
      end
      error_count++;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] got,
                                       input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
      end
   endfunction

   function automatic int unsigned clamp_side(input logic [SIDE_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      if (raw > MAX_SIDE) begin
         return MAX_SIDE;
      end
      return raw;
   endfunction

   // centred grid coordinate, even sides round the half down
   function automatic logic signed [POS_W-1:0] grid_offset(input int unsigned idx,
                                                           input int unsigned side);
      longint half;
      longint offs;
      half = longint'((side - 1) >> 1);
      offs = (longint'(idx) - half) * longint'(mesh_cfg.block_size);
      return offs[POS_W-1:0];
   endfunction

   function automatic void predict_mesh_items(input req_data_type px);
      int unsigned     cols, rows, c, w, luma, hgt;
      longint unsigned base_idx, below, prod;
      logic            last_col, last_row, tri_cell;
      rsp_data_type    vtx, tri_a, tri_b;
      cols = clamp_side(mesh_cfg.grid_columns);
      rows = clamp_side(mesh_cfg.grid_rows);
      c = col_ctr;
      w = row_ctr;
      luma = LUMA_R * px.pixel_red + LUMA_G * px.pixel_green + LUMA_B * px.pixel_blue;
      hgt = (luma * 256 + HGT_ROUND) / HGT_DIV;
      last_col = (c + 1 >= cols);
      last_row = (w + 1 >= rows);
      tri_cell = !last_col && !last_row;

      // first pixel of a heightmap restarts the running maximum
      if (c == 0 && w == 0) begin
         peak_hgt = hgt[HGT_W-1:0];
      end else if (hgt > peak_hgt) begin
         peak_hgt = hgt[HGT_W-1:0];
      end

      vtx = '0;
      vtx.item_kind = KIND_VERTEX;
      vtx.pos_x = grid_offset(c, cols);
      vtx.pos_height = hgt[HGT_W-1:0];
      vtx.pos_z = grid_offset(w, rows);
      prod = longint'(c) * mesh_cfg.u_step;
      vtx.tex_u = prod[TEX_W-1:0];
      prod = longint'(w) * mesh_cfg.v_step;
      vtx.tex_v = prod[TEX_W-1:0];
      vtx.peak_height = peak_hgt;
      vtx.run_end = !tri_cell;
      expected_items = {expected_items, vtx};

      if (tri_cell) begin
         base_idx = longint'(w) * cols + c;
         below = base_idx + cols;
         tri_a = '0;
         tri_a.item_kind = KIND_TRIANGLE;
         tri_a.corner_a = IDX_W'(base_idx);
         tri_a.corner_b = IDX_W'(below);
         tri_a.corner_c = IDX_W'(base_idx + 1);
         tri_a.peak_height = peak_hgt;
         tri_b = tri_a;
         tri_b.corner_a = IDX_W'(base_idx + 1);
         tri_b.corner_b = IDX_W'(below);
         tri_b.corner_c = IDX_W'(below + 1);
         tri_b.run_end = 1'b1;
         expected_items = {expected_items, tri_a, tri_b};
      end

      if (last_col) begin
         col_ctr = 0;
         row_ctr = last_row ? 0 : w + 1;
      end else begin
         col_ctr = c + 1;
      end
   endfunction

   task automatic send_pixel(input req_data_type px);
      int gap;
      gap = pacing ? $urandom_range(0, MAX_WAIT) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_full !== 1'b0);
      predict_mesh_items(px);
      pixels_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_items.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_GRID_COLUMNS: mesh_cfg.grid_columns = value[SIDE_W-1:0];
         CSR_GRID_ROWS:    mesh_cfg.grid_rows = value[SIDE_W-1:0];
         CSR_BLOCK_SIZE:   mesh_cfg.block_size = value[BLK_W-1:0];
         CSR_U_STEP:       mesh_cfg.u_step = value[STEP_W-1:0];
         CSR_V_STEP:       mesh_cfg.v_step = value[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DW-1:0] cols, rows, blk, u_inc, v_inc);
      wait_for_drain();
      write_reg(CSR_GRID_COLUMNS, cols);
      write_reg(CSR_GRID_ROWS, rows);
      write_reg(CSR_BLOCK_SIZE, blk);
      write_reg(CSR_U_STEP, u_inc);
      write_reg(CSR_V_STEP, v_inc);
   endtask

   function automatic req_data_type random_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return req_data_type'(24'($urandom));
      endcase
   endfunction

   function automatic logic [CSR_DW-1:0] pick_side();
      logic [CSR_DW-1:0] raw;
      case ($urandom_range(0, 19))
         0: raw = '0;
         1: raw = CSR_DW'(1);
         2: raw = CSR_DW'(2);
         3: raw = CSR_DW'(MAX_SIDE);
         4: raw = CSR_DW'($urandom_range(4, 40));
         5: raw = CSR_DW'(2 * $urandom_range(5, 7) + 1);
         default: raw = CSR_DW'(2 * $urandom_range(1, 4) + 1);
      endcase
      // junk above the register width must be dropped
      if ($urandom_range(0, 7) == 0) begin
         raw[CSR_DW-1:SIDE_W] = (CSR_DW - SIDE_W)'($urandom);
      end
      return raw;
   endfunction

   function automatic logic [CSR_DW-1:0] pick_block();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return CSR_DW'(1);
         2: return CSR_DW'(16'hFFFF);
         default: return CSR_DW'($urandom_range(1, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [CSR_DW-1:0] pick_step();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // default 3x3 grid, channel extremes and alternating bit patterns
   task automatic test_pixel_extremes();
      send_pixel(req_data_type'(24'h000000));
      send_pixel(req_data_type'(24'hFFFFFF));
      send_pixel(req_data_type'(24'hFF0000));
      send_pixel(req_data_type'(24'h00FF00));
      send_pixel(req_data_type'(24'h0000FF));
      send_pixel(req_data_type'(24'hAA55AA));
      send_pixel(req_data_type'(24'h55AA55));
      send_pixel(req_data_type'(24'h010101));
      send_pixel(req_data_type'(24'hFEFEFE));
   endtask

   // new heightmap after a bright one: the maximum starts again from a dim pixel
   task automatic test_peak_restart();
      send_pixel(req_data_type'(24'h202020));
      send_pixel(req_data_type'(24'h000000));
   endtask

   task automatic test_size_limits();
      // zero width clamps to one column, even height, smallest spacing
      configure(24'h000000, 24'h000002, 24'h000001, 24'h000000, 24'hFFFFFF);
      repeat (3) send_pixel(random_pixel());
      configure(24'hFFFFFF, 24'hFFFFFF, 24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF);
      write_reg(CSR_SPARE, 24'h5A5A5A);
      repeat (3) send_pixel(random_pixel());
   endtask

   // shrink the grid under the counters mid-heightmap
   task automatic test_counter_beyond_size();
      configure(24'd7, 24'd5, 24'd256, 24'd65536, 24'd65536);
      repeat (8) send_pixel(random_pixel());
      configure(24'd3, 24'd1, 24'd384, 24'd4096, 24'd8192);
      repeat (3) send_pixel(random_pixel());
   endtask

   // receiver holds off while pixels keep coming, so the input side backs up
   task automatic test_output_stall();
      configure(24'd5, 24'd5, 24'd1280, 24'd32768, 24'd32768);
      pacing = 1'b0;
      rsp_hold = 120;
      repeat (20) send_pixel(random_pixel());
      pacing = 1'b1;
   endtask

   task automatic test_random_frames();
      int unsigned cols, rows, total, count;
      while (pixels_sent < PIXEL_GOAL) begin
         pacing = ($urandom_range(0, 3) != 0);
         configure(pick_side(), pick_side(), pick_block(), pick_step(), pick_step());
         if ($urandom_range(0, 9) == 0) begin
            write_reg(CSR_SPARE, 24'($urandom));
         end
         cols = clamp_side(mesh_cfg.grid_columns);
         rows = clamp_side(mesh_cfg.grid_rows);
         total = cols * rows;
         // mostly whole heightmaps, now and then a truncated one
         if (total > 120 || $urandom_range(0, 7) == 0) begin
            count = $urandom_range(1, (total < 60) ? total : 60);
         end else begin
            count = total;
         end
         repeat (count) send_pixel(random_pixel());
      end
      pacing = 1'b1;
   endtask

   // result side: random stalls per transfer, or one long hold when asked
   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = pacing ? $urandom_range(0, MAX_WAIT) : 0;
         if (rsp_hold > 0) begin
            stall = rsp_hold;
            rsp_hold = 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_data_type want;
      if (!reset && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
         if (expected_items.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      results_seen));
         end else begin
            want = expected_items.pop_front();
            check_field("item_kind", rsp_data.item_kind, want.item_kind);
            check_field("pos_x", rsp_data.pos_x, want.pos_x);
            check_field("pos_height", rsp_data.pos_height, want.pos_height);
            check_field("pos_z", rsp_data.pos_z, want.pos_z);
            check_field("tex_u", rsp_data.tex_u, want.tex_u);
            check_field("tex_v", rsp_data.tex_v, want.tex_v);
            check_field("corner_a", rsp_data.corner_a, want.corner_a);
            check_field("corner_b", rsp_data.corner_b, want.corner_b);
            check_field("corner_c", rsp_data.corner_c, want.corner_c);
            check_field("peak_height", rsp_data.peak_height, want.peak_height);
            check_field("run_end", rsp_data.run_end, want.run_end);
         end
         results_seen++;
      end
   end

   // any transfer on any port counts as progress
   always @(posedge clock) begin
      if (reset || (req_push === 1'b1 && req_full === 1'b0) ||
          (rsp_pop === 1'b1 && rsp_empty === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pixel_extremes();
      test_peak_restart();
      test_size_limits();
      test_counter_beyond_size();
      test_output_stall();
      test_random_frames();

      wait_for_drain();
      repeat (12) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
design/hmg_pkg.sv
design/hmg_queue.sv
design/hmg_front.sv
design/hmg_back.sv
design/heightmap_grid_mesh_generator_top.sv
design/hmg_checker.sv
verif/heightmap_grid_mesh_generator_top_tb.sv
